@@ src/double_ended_queue_assert.svh @@
// Assertion macros used by the double-ended queue checker.
// Needs nothing else; the including file supplies clock, reset and signals.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/dq_pkg.sv @@
// Shared types, sizes and helpers for the double-ended queue.
// No dependencies.
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_DUMP       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic [4:0]         count;
      logic               last;
   } rsp_type;

   // base + off modulo DEPTH; off never exceeds DEPTH
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return ADDR_W'(sum);
   endfunction

   function automatic rsp_type make_rsp(input status_type             status,
                                        input logic [DATA_WIDTH-1:0] data,
                                        input logic [CNT_W-1:0]      count,
                                        input logic                  last);
      rsp_type r;
      r.status = status;
      r.data   = 32'(data);
      r.count  = 5'(count);
      r.last   = last;
      return r;
   endfunction

endpackage

@@ src/dq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read; no dependencies.
module dq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/double_ended_queue.sv @@
// Double-ended queue of signed words held in a circular RAM.
// Depends on dq_pkg and dq_ram.
//
// Usage:
//   req channel: req_valid / req_stall / req_item carries one transaction
//   (action, value). rsp channel: rsp_valid / rsp_stall / rsp_item returns
//   status, data, count after the operation, and last.
//   A push, a rejected push, an empty pop or dump and an unused action code
//   each give one result in the cycle after acceptance; unless rsp stalls,
//   the block takes the next transaction in that same cycle, so these run at
//   one per cycle. A pop reads the RAM into its registered read data, and
//   its result is then loaded into the result register. A dump of N words
//   streams N results, one per cycle while rsp is not stalled, each taken
//   from the registered read data. New transactions are held off while a
//   read is outstanding.
//   Reset empties the queue (front and count to zero); RAM contents are not
//   cleared and need no clearing pass. A stall on rsp holds the result
//   register and backs up into req_stall; no result is dropped.
module double_ended_queue
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  dump_ff, dump_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  out_free;
   logic                  req_fire;
   logic                  is_full;
   logic                  is_empty;
   logic                  final_word;
   logic [CNT_W-1:0]      idx_next;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   dq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = (state_ff != S_IDLE) || !out_free;
      req_fire   = req_valid && !req_stall;
      is_full    = (count_ff == CNT_W'(DEPTH));
      is_empty   = (count_ff == '0);
      idx_next   = idx_ff + CNT_W'(1);
      final_word = !dump_ff || (idx_next == count_ff);

      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      dump_in      = dump_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = wrap_add(front_ff, count_ff);
      wr_data      = DATA_WIDTH'(req_item.value);
      rd_en        = 1'b0;
      rd_addr      = front_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               case (req_item.action)
                  ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_in = make_rsp(ST_FULL, '0, count_ff, 1'b1);
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (req_item.action == ACT_PUSH_FRONT) begin
                           front_in = (front_ff == '0) ? ADDR_W'(DEPTH - 1)
                                                       : front_ff - ADDR_W'(1);
                           wr_addr  = front_in;
                        end
                        rsp_in = make_rsp(ST_OK, '0, count_in, 1'b1);
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     if (is_empty) begin
                        rsp_in = make_rsp(ST_EMPTY, '0, count_ff, 1'b1);
                     end else begin
                        // result is issued once the RAM data returns
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        dump_in      = 1'b0;
                        state_in     = S_READ;
                        if (req_item.action == ACT_POP_FRONT) begin
                           front_in = (front_ff == ADDR_W'(DEPTH - 1)) ? '0
                                                                     : front_ff + ADDR_W'(1);
                        end else begin
                           rd_addr = wrap_add(front_ff, count_in);
                        end
                     end
                  end
                  ACT_DUMP: begin
                     if (is_empty) begin
                        rsp_in = make_rsp(ST_EMPTY, '0, count_ff, 1'b1);
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        idx_in       = '0;
                        dump_in      = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                     rsp_in = make_rsp(ST_OK, '0, count_ff, 1'b1);
                  end
               endcase
            end
         end
         S_READ: begin
            // rd_data holds until the next read, so a stalled output just waits
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(ST_OK, rd_data, count_ff, final_word);
               if (final_word) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_next;
                  rd_en   = 1'b1;
                  rd_addr = wrap_add(front_ff, idx_next);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         dump_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         dump_ff      <= dump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ src/dq_checker.sv @@
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_assert.svh.
`include "double_ended_queue_assert.svh"

module dq_checker
   import dq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_item,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   `DQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "stalled result changed")

   `DQ_ASSERT_SAME(a_empty_fields, clock, reset, rsp_valid && (rsp_item.status == ST_EMPTY), (rsp_item.count == 5'd0) && (rsp_item.data == 32'sd0) && rsp_item.last, "empty result malformed")

   `DQ_ASSERT_SAME(a_full_fields, clock, reset, rsp_valid && (rsp_item.status == ST_FULL), (rsp_item.count == 5'(DEPTH)) && (rsp_item.data == 32'sd0) && rsp_item.last, "full result malformed")

   `DQ_ASSERT_SAME(a_dump_body, clock, reset, rsp_valid && !rsp_item.last, (rsp_item.status == ST_OK) && (rsp_item.count != 5'd0) && req_stall, "dump word malformed")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
